// ===== design/isc_pkg.sv =====
// Shared constants, codes and types for the interval stabbing counter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package isc_pkg;

  // Table geometry
  localparam int MAX_INTERVALS = 1024;
  localparam int ADDR_W        = $clog2(MAX_INTERVALS);
  localparam int COUNT_W       = 11;
  localparam int COORD_W       = 32;
  localparam int OP_W          = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Full-table occupancy at the count width
  localparam logic [COUNT_W-1:0] OCC_FULL = COUNT_W'(MAX_INTERVALS);

  // Table write port
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } tbl_wr_t;

  // Table read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  // Registered read data with its valid flag
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } tbl_data_t;

endpackage

`default_nettype wire

// ===== design/isc_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on isc_pkg for field widths.
`default_nettype none

interface isc_req_if;
  import isc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] interval_start;
  logic [COORD_W-1:0] interval_end;
  logic [COORD_W-1:0] query_point;

  modport source (output valid, operation, interval_start, interval_end, query_point,
                  input ready);
  modport sink   (input valid, operation, interval_start, interval_end, query_point,
                  output ready);
endinterface

interface isc_rsp_if;
  import isc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] cover_count;
  logic               status;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, cover_count, status, stored_count, input ready);
  modport sink   (input valid, cover_count, status, stored_count, output ready);
endinterface

`default_nettype wire

// ===== design/isc_table.sv =====
// Interval table: start and end bounds, one write and one registered read per cycle.
// Depends on isc_pkg.
`default_nettype none

module isc_table (
  input  logic               clk,
  input  logic               rst,
  input  isc_pkg::tbl_wr_t   wr,
  input  isc_pkg::tbl_rd_t   rd,
  output isc_pkg::tbl_data_t rdata
);
  import isc_pkg::*;

  logic [COORD_W-1:0] lo_mem [MAX_INTERVALS];
  logic [COORD_W-1:0] hi_mem [MAX_INTERVALS];
  logic [COORD_W-1:0] lo_q;
  logic [COORD_W-1:0] hi_q;
  logic               rvalid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      lo_mem[wr.addr] <= wr.lo;
      hi_mem[wr.addr] <= wr.hi;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      lo_q <= lo_mem[rd.addr];
      hi_q <= hi_mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= rd.en;
    end
  end

  assign rdata.valid = rvalid;
  assign rdata.lo    = lo_q;
  assign rdata.hi    = hi_q;

endmodule

`default_nettype wire

// ===== design/isc_cmp.sv =====
// Shared containment check and hit accumulator used once per scanned entry.
// Depends on isc_pkg.
`default_nettype none

module isc_cmp (
  input  logic                        clk,
  input  logic                        clr,
  input  isc_pkg::tbl_data_t          rdata,
  input  logic [isc_pkg::COORD_W-1:0] point,
  output logic [isc_pkg::COUNT_W-1:0] count
);
  import isc_pkg::*;

  logic hit;

  // Inclusive compare: start <= point <= end
  assign hit = rdata.valid && (rdata.lo <= point) && (point <= rdata.hi);

  // Hit counter, cleared at the start of each table scan
  always_ff @(posedge clk) begin
    if (clr) begin
      count <= '0;
    end else if (hit) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/interval_stabbing_counter.sv =====
// Interval stabbing counter. Holds up to 1024 closed intervals [start, end] and answers
// clear, add and query operations, one response transfer per request transfer. Clear,
// add and unused codes, and a query on an empty table, complete without a scan. A
// query walks the stored entries through the table's single read port and one shared
// comparator, one entry per cycle. The block takes no new request while a query is
// in progress.
// Depends on isc_pkg, isc_if, isc_table and isc_cmp.
`default_nettype none

module interval_stabbing_counter (
  input  logic      clk,
  input  logic      rst,
  isc_req_if.sink   req,
  isc_rsp_if.source rsp
);
  import isc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [COUNT_W-1:0] occ;
  logic [COUNT_W-1:0] occ_next;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] idx_inc;
  logic [COORD_W-1:0] point;
  logic               ovalid;
  logic [COUNT_W-1:0] ocover;
  logic               ostatus;
  logic [COUNT_W-1:0] ostored;

  logic               accept;
  logic               slot_free;
  logic               full;
  logic               is_add;
  logic               is_query;
  logic               start_scan;
  logic               fast_done;
  logic               scan_done;
  logic [COUNT_W-1:0] hits;

  tbl_wr_t   wr;
  tbl_rd_t   rd;
  tbl_data_t rdata;

  // Handshake decode
  assign slot_free  = !ovalid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && slot_free;
  assign accept     = req.valid && req.ready;
  assign full       = (occ == OCC_FULL);
  assign is_add     = (req.operation == OP_ADD);
  assign is_query   = (req.operation == OP_QUERY);
  assign start_scan = accept && is_query && (occ != '0);
  assign fast_done  = accept && !start_scan;
  assign scan_done  = (state == S_DONE) && slot_free;
  assign idx_inc    = idx + COUNT_W'(1);

  // Occupancy update
  always_comb begin
    occ_next = occ;
    if (accept) begin
      case (req.operation)
        OP_CLEAR: occ_next = '0;
        OP_ADD:   if (!full) occ_next = occ + COUNT_W'(1);
        default:  occ_next = occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // Table ports
  always_comb begin
    wr.en   = accept && is_add && !full;
    wr.addr = occ[ADDR_W-1:0];
    wr.lo   = req.interval_start;
    wr.hi   = req.interval_end;
    rd.en   = (state == S_SCAN);
    rd.addr = idx[ADDR_W-1:0];
  end

  isc_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  isc_cmp u_cmp (
    .clk   (clk),
    .clr   (start_scan),
    .rdata (rdata),
    .point (point),
    .count (hits)
  );

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_scan) begin
            state <= S_SCAN;
            idx   <= '0;
          end
        end
        S_SCAN: begin
          if (idx_inc == occ) begin
            state <= S_WAIT;
          end else begin
            idx <= idx_inc;
          end
        end
        S_WAIT: state <= S_DONE;
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query point holds for the whole scan
  always_ff @(posedge clk) begin
    if (start_scan) point <= req.query_point;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (fast_done || scan_done) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_done) begin
      ocover  <= '0;
      ostatus <= (is_add && full) ? STATUS_FULL : STATUS_OK;
      ostored <= occ_next;
    end else if (scan_done) begin
      ocover  <= hits;
      ostatus <= STATUS_OK;
      ostored <= occ;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.cover_count  = ocover;
  assign rsp.status       = ostatus;
  assign rsp.stored_count = ostored;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_FULL)
    else $error("occupancy above table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx < occ))
    else $error("scan address beyond stored entries");

  a_cover_bound: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (ocover <= ostored))
    else $error("cover count above stored count");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && is_add && full) |=> (ovalid && ostatus == STATUS_FULL && occ == OCC_FULL))
    else $error("add to full table not refused");

endmodule

`default_nettype wire
